@@ rtl/mmab_pkg.sv @@
// Package with the shared types and constants of the matrix multiply-add block.
package mmab_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS_M         = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INNER_K        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS_N         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RHS_TRANSPOSED = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIAS_MODE      = 3'd4;

    localparam logic [1:0] BIAS_NONE = 2'd0;
    localparam logic [1:0] BIAS_FULL = 2'd1;
    localparam logic [1:0] BIAS_ROW  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_LEFT  = 2'd0,
        CMD_LOAD_RIGHT = 2'd1,
        CMD_LOAD_BIAS  = 2'd2,
        CMD_START      = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [8:0]         index;
        logic signed [15:0] element_value;
        logic signed [39:0] bias_value;
    } item_word_t;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [47:0] out_value;
        logic               last;
    } result_word_t;

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic load_out;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_k;
        logic pipe_busy;
        logic last_elem;
    } dp_status_t;

endpackage

@@ rtl/matrix_multiply_add_bias.sv @@
// Top level of the matrix multiply-add block: configuration registers, controller and datapath.
// Load words (left, right or bias element) are taken one per cycle while the block is idle; a
// start word then holds item_stall high while the block computes left times right plus bias and
// delivers every result in row-major order with last set on the final one. Each result is
// computed by the single multiply-accumulate unit that walks the inner dimension through one
// read port of each element memory and is held while result_stall is high. Loads whose index
// lies past the configured matrix size are dropped, and stores are not cleared by reset.
module matrix_multiply_add_bias #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 8,
    parameter int MAX_INNER = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  mmab_pkg::item_word_t                 item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output mmab_pkg::result_word_t               result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmab_pkg::CFG_ADDR_W-1:0]      cfg_index,
    input  logic [mmab_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int I_W1 = $clog2(MAX_ROWS + 1);
    localparam int J_W1 = $clog2(MAX_COLS + 1);
    localparam int K_W1 = $clog2(MAX_INNER + 1);

    logic [3:0]          rows_m_reg;
    logic [6:0]          inner_k_reg;
    logic [3:0]          cols_n_reg;
    logic                rhs_transposed_reg;
    logic [1:0]          bias_mode_reg;
    logic [I_W1-1:0]     eff_m;
    logic [K_W1-1:0]     eff_k;
    logic [J_W1-1:0]     eff_n;
    mmab_pkg::ctrl_cmd_t  ctl;
    mmab_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg         <= 4'd1;
            inner_k_reg        <= 7'd1;
            cols_n_reg         <= 4'd1;
            rhs_transposed_reg <= 1'b0;
            bias_mode_reg      <= mmab_pkg::BIAS_NONE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mmab_pkg::CFG_ROWS_M:         rows_m_reg         <= cfg_data[3:0];
                mmab_pkg::CFG_INNER_K:        inner_k_reg        <= cfg_data[6:0];
                mmab_pkg::CFG_COLS_N:         cols_n_reg         <= cfg_data[3:0];
                mmab_pkg::CFG_RHS_TRANSPOSED: rhs_transposed_reg <= cfg_data[0];
                mmab_pkg::CFG_BIAS_MODE:      bias_mode_reg      <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A zero dimension counts as one and a dimension above the maximum saturates.
    always_comb
    begin
        if (rows_m_reg == 4'd0)
        begin
            eff_m = I_W1'(1);
        end
        else if (int'(rows_m_reg) > MAX_ROWS)
        begin
            eff_m = I_W1'(MAX_ROWS);
        end
        else
        begin
            eff_m = I_W1'(rows_m_reg);
        end

        if (inner_k_reg == 7'd0)
        begin
            eff_k = K_W1'(1);
        end
        else if (int'(inner_k_reg) > MAX_INNER)
        begin
            eff_k = K_W1'(MAX_INNER);
        end
        else
        begin
            eff_k = K_W1'(inner_k_reg);
        end

        if (cols_n_reg == 4'd0)
        begin
            eff_n = J_W1'(1);
        end
        else if (int'(cols_n_reg) > MAX_COLS)
        begin
            eff_n = J_W1'(MAX_COLS);
        end
        else
        begin
            eff_n = J_W1'(cols_n_reg);
        end
    end

    mmab_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_cmd     (item.cmd),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .ctl          (ctl)
    );

    mmab_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_INNER (MAX_INNER)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .item           (item),
        .eff_m          (eff_m),
        .eff_k          (eff_k),
        .eff_n          (eff_n),
        .rhs_transposed (rhs_transposed_reg),
        .bias_mode      (bias_mode_reg),
        .result         (result)
    );

endmodule

@@ rtl/mmab_ctrl.sv @@
// Controller state machine that sequences loads, the inner-product walk and result hand-off.
module mmab_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  mmab_pkg::cmd_t          item_cmd,
    output logic                    item_stall,
    output logic                    result_valid,
    input  logic                    result_stall,
    input  mmab_pkg::dp_status_t    sts,
    output mmab_pkg::ctrl_cmd_t     ctl
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_cmd == mmab_pkg::CMD_START)
                    begin
                        ctl.start  = 1'b1;
                        state_next = S_RUN;
                    end
                    else
                    begin
                        ctl.load = 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                ctl.issue = 1'b1;
                if (sts.last_k)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    if (sts.last_elem)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.advance = 1'b1;
                        state_next  = S_RUN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);

endmodule

@@ rtl/mmab_datapath.sv @@
// Datapath with the matrix memories, index counters, multiply-accumulate pipeline and result register.
module mmab_datapath #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 8,
    parameter int MAX_INNER = 64,
    localparam int I_W1 = $clog2(MAX_ROWS + 1),
    localparam int J_W1 = $clog2(MAX_COLS + 1),
    localparam int K_W1 = $clog2(MAX_INNER + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mmab_pkg::ctrl_cmd_t        ctl,
    output mmab_pkg::dp_status_t       sts,
    input  mmab_pkg::item_word_t       item,
    input  logic [I_W1-1:0]            eff_m,
    input  logic [K_W1-1:0]            eff_k,
    input  logic [J_W1-1:0]            eff_n,
    input  logic                       rhs_transposed,
    input  logic [1:0]                 bias_mode,
    output mmab_pkg::result_word_t     result
);

    localparam int L_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int R_DEPTH = MAX_INNER * MAX_COLS;
    localparam int B_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int L_AW = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;
    localparam int R_AW = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;
    localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int I_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int J_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int K_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int MK_W = I_W1 + K_W1;
    localparam int KN_W = K_W1 + J_W1;
    localparam int MN_W = I_W1 + J_W1;

    logic signed [15:0] left_mem  [L_DEPTH];
    logic signed [15:0] right_mem [R_DEPTH];
    logic signed [39:0] bias_mem  [B_DEPTH];

    logic [I_W-1:0]     i_reg;
    logic [J_W-1:0]     j_reg;
    logic [K_W-1:0]     kk_reg;
    logic               p1_reg;
    logic               p2_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic signed [39:0] bias_rd_reg;
    logic signed [31:0] prod_reg;
    logic signed [47:0] acc_reg;
    logic [2:0]         row_reg;
    logic [2:0]         col_reg;
    logic signed [47:0] value_reg;
    logic               last_reg;

    logic [MK_W-1:0]    lim_left;
    logic [KN_W-1:0]    lim_right;
    logic [MN_W-1:0]    lim_bias;
    logic [L_AW-1:0]    left_addr;
    logic [R_AW-1:0]    right_addr;
    logic [B_AW-1:0]    bias_addr;
    logic               last_i;
    logic               last_j;
    logic signed [47:0] prod_ext;
    logic signed [47:0] bias_term;

    assign lim_left  = MK_W'(eff_m) * MK_W'(eff_k);
    assign lim_right = KN_W'(eff_k) * KN_W'(eff_n);
    assign lim_bias  = MN_W'(eff_m) * MN_W'(eff_n);

    assign left_addr = L_AW'(i_reg) * L_AW'(eff_k) + L_AW'(kk_reg);
    assign right_addr = rhs_transposed
        ? (R_AW'(j_reg) * R_AW'(eff_k) + R_AW'(kk_reg))
        : (R_AW'(kk_reg) * R_AW'(eff_n) + R_AW'(j_reg));
    assign bias_addr = (bias_mode == mmab_pkg::BIAS_FULL)
        ? (B_AW'(i_reg) * B_AW'(eff_n) + B_AW'(j_reg))
        : B_AW'(j_reg);

    assign last_i = (I_W1'(i_reg) == eff_m - I_W1'(1));
    assign last_j = (J_W1'(j_reg) == eff_n - J_W1'(1));

    assign sts.last_k    = (K_W1'(kk_reg) == eff_k - K_W1'(1));
    assign sts.pipe_busy = p1_reg | p2_reg;
    assign sts.last_elem = last_i & last_j;

    assign prod_ext  = {{16{prod_reg[31]}}, prod_reg};
    assign bias_term = ((bias_mode == mmab_pkg::BIAS_FULL) || (bias_mode == mmab_pkg::BIAS_ROW))
        ? {{8{bias_rd_reg[39]}}, bias_rd_reg} : 48'sd0;

    always_ff @(posedge clk)
    begin
        if (ctl.load && item.cmd == mmab_pkg::CMD_LOAD_LEFT && item.index < lim_left)
        begin
            left_mem[L_AW'(item.index)] <= item.element_value;
        end
        if (ctl.issue)
        begin
            a_reg <= left_mem[left_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && item.cmd == mmab_pkg::CMD_LOAD_RIGHT && item.index < lim_right)
        begin
            right_mem[R_AW'(item.index)] <= item.element_value;
        end
        if (ctl.issue)
        begin
            b_reg <= right_mem[right_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && item.cmd == mmab_pkg::CMD_LOAD_BIAS && item.index < lim_bias)
        begin
            bias_mem[B_AW'(item.index)] <= item.bias_value;
        end
        if (ctl.issue)
        begin
            bias_rd_reg <= bias_mem[bias_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg  <= '0;
            j_reg  <= '0;
            kk_reg <= '0;
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= ctl.issue;
            p2_reg <= p1_reg;
            if (ctl.start)
            begin
                i_reg  <= '0;
                j_reg  <= '0;
                kk_reg <= '0;
            end
            else if (ctl.issue)
            begin
                if (sts.last_k)
                begin
                    kk_reg <= '0;
                end
                else
                begin
                    kk_reg <= kk_reg + K_W'(1);
                end
            end
            else if (ctl.advance)
            begin
                if (last_j)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + I_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + J_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(a_reg) * 32'(b_reg);
        if (ctl.start || ctl.advance)
        begin
            acc_reg <= 48'sd0;
        end
        else if (p2_reg)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
        if (ctl.load_out)
        begin
            row_reg   <= 3'(i_reg);
            col_reg   <= 3'(j_reg);
            value_reg <= acc_reg + bias_term;
            last_reg  <= sts.last_elem;
        end
    end

    assign result.row       = row_reg;
    assign result.col       = col_reg;
    assign result.out_value = value_reg;
    assign result.last      = last_reg;

endmodule

@@ rtl/mmab_checker.sv @@
// Port-level checker for the matrix multiply-add block and its bind to the top level.
module mmab_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_stall,
    input mmab_pkg::item_word_t   item,
    input logic                   result_valid,
    input logic                   result_stall,
    input mmab_pkg::result_word_t result
);

    // Results appear only while a run holds off new words.
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("result shown while input side is open");

    // An accepted start word closes the input side on the next cycle.
    a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.cmd == mmab_pkg::CMD_START) |=> item_stall)
        else $error("start word did not begin a run");

    // Once the final word of a run is taken, no further result follows at once and the input side reopens.
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last) |=> (!result_valid && !item_stall))
        else $error("run did not end after its last word");

    // A stalled result word holds its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result word changed");

endmodule

bind matrix_multiply_add_bias mmab_checker u_mmab_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
